@@ hdl/sine_cosine_taylor_defines.svh @@
// Assertion macros for the sine/cosine RTL.
// Depends on clk_i and rst_ni existing in the module that uses them.
`ifndef SINE_COSINE_TAYLOR_DEFINES_SVH
`define SINE_COSINE_TAYLOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define STC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stc assertion failed");
`define STC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("stc forbidden condition");
`else
`define STC_ASSERT(lbl, prop)
`define STC_NEVER(lbl, expr)
`endif
`endif

@@ hdl/stc_pkg.sv @@
// Types and constants for the sine/cosine Taylor pipeline.
// No dependencies.
`default_nettype none
package stc_pkg;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned AX_W    = 32;
  localparam int unsigned XSQ_W   = 34;
  localparam int unsigned TERM_W  = 34;
  localparam int unsigned SUM_W   = 37;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned FRAC    = 30;

  localparam logic [31:0] PI_Q24         = 32'd52707179;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
  localparam logic [TERM_W-1:0] ONE_TERM = TERM_W'(1) << FRAC;

  typedef struct packed {
    logic valid;
    logic neg;
  } stc_ctl_t;
endpackage
`default_nettype wire

@@ hdl/sine_cosine_taylor.sv @@
// Channel   Signals                        Direction
// in        in_valid_i/in_stall_o, angle_i  angle Q8.24 in
// out       out_valid_o/out_stall_i,        sine, cosine Q2.30 out
//           sine_o, cosine_o
// One transaction per cycle unless the output stalls; the term pipeline does
// one multiply per sine and cosine term per stage.
// Reset clears all valid bits; payload registers are not reset.
// A stalled full output freezes every stage and stalls the input.
// Depends on stc_pkg, stc_reduce, stc_series and the defines header.
`include "sine_cosine_taylor_defines.svh"
`default_nettype none
module sine_cosine_taylor import stc_pkg::*; #(
  parameter int unsigned SERIES_TERMS       = 8,
  parameter int unsigned TURN_FRACTION_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [ANGLE_W-1:0] angle_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [RES_W-1:0]      sine_o,
  output logic signed [RES_W-1:0]      cosine_o
);
  localparam logic signed [SUM_W-1:0] POS_ONE = SUM_W'(ONE_TERM);
  localparam logic signed [SUM_W-1:0] NEG_ONE = -POS_ONE;

  logic                    en;
  logic                    in_v_q;
  logic [ANGLE_W-1:0]      angle_q;
  stc_ctl_t                red_ctl, sq_ctl_q, ser_ctl;
  logic [AX_W-1:0]         red_ax, ax_q;
  logic [63:0]             sq_prod;
  logic [XSQ_W-1:0]        xsq_q;
  logic signed [SUM_W-1:0] ss, sc, s_sgn, s_cl, c_cl;
  logic                    out_v_q;
  logic signed [RES_W-1:0] sine_q, cos_q;

  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      sq_ctl_q <= '0;
      out_v_q  <= 1'b0;
    end else if (en) begin
      in_v_q   <= in_valid_i;
      sq_ctl_q <= red_ctl;
      out_v_q  <= ser_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_i;
    end
  end

  stc_reduce #(.TURN_FRACTION_BITS(TURN_FRACTION_BITS)) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .angle_i (angle_q),
    .ctl_o   (red_ctl),
    .ax_o    (red_ax)
  );

  assign sq_prod = 64'(red_ax) * 64'(red_ax);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= red_ax;
      xsq_q <= sq_prod[FRAC +: XSQ_W];
    end
  end

  stc_series #(.SERIES_TERMS(SERIES_TERMS)) u_series (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (sq_ctl_q),
    .ax_i       (ax_q),
    .xsq_i      (xsq_q),
    .ctl_o      (ser_ctl),
    .sine_sum_o (ss),
    .cos_sum_o  (sc)
  );

  assign s_sgn = ser_ctl.neg ? -ss : ss;
  assign s_cl  = (s_sgn > POS_ONE) ? POS_ONE : ((s_sgn < NEG_ONE) ? NEG_ONE : s_sgn);
  assign c_cl  = (sc > POS_ONE) ? POS_ONE : ((sc < NEG_ONE) ? NEG_ONE : sc);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sine_q <= s_cl[RES_W-1:0];
      cos_q  <= c_cl[RES_W-1:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign sine_o      = sine_q;
  assign cosine_o    = cos_q;

  `STC_ASSERT(a_sine_range, out_valid_o |-> (sine_o <= 32'sd1073741824 && sine_o >= -32'sd1073741824))
  `STC_ASSERT(a_cos_range, out_valid_o |-> (cosine_o <= 32'sd1073741824 && cosine_o >= -32'sd1073741824))
  `STC_ASSERT(a_accept_enters, (in_valid_i && !in_stall_o) |=> in_v_q)
  `STC_NEVER(a_stall_while_empty, in_stall_o && !out_valid_o)
endmodule
`default_nettype wire

@@ hdl/stc_reduce.sv @@
// Range reduction: magnitude, turn fraction and Q.30 argument, two stages.
// Depends on stc_pkg.
`default_nettype none
module stc_reduce import stc_pkg::*; #(
  parameter int unsigned TURN_FRACTION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [ANGLE_W-1:0] angle_i,
  output stc_ctl_t                ctl_o,
  output logic [AX_W-1:0]         ax_o
);
  localparam int unsigned F  = TURN_FRACTION_BITS;
  localparam int unsigned PW = F + 32;

  logic [31:0]   mag;
  logic [63:0]   prod1;
  stc_ctl_t      ctl1_q, ctl2_q;
  logic          big_q;
  logic [F-1:0]  turns_q;
  logic [25:0]   small_q;
  logic [F-1:0]  fr;
  logic [F-1:0]  fmag;
  logic [PW-1:0] prod2;
  logic          xneg;
  logic [AX_W-1:0] ax_d, ax_q;

  assign mag   = angle_i[31] ? (~angle_i + 32'd1) : angle_i;
  assign prod1 = 64'(mag) * 64'(INV_TWO_PI_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{valid: valid_i, neg: angle_i[31]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big_q   <= (mag > PI_Q24);
      turns_q <= prod1[56-F +: F];
      small_q <= mag[25:0];
    end
  end

  assign fr    = ctl1_q.neg ? (~turns_q + F'(1)) : turns_q;
  assign fmag  = fr[F-1] ? (~fr + F'(1)) : fr;
  assign prod2 = PW'(fmag) * PW'(TWO_PI_Q29) + (PW'(1) << (F - 2));
  assign xneg  = big_q ? fr[F-1] : ctl1_q.neg;
  assign ax_d  = big_q ? prod2[F-1 +: AX_W] : {small_q, 6'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl2_q <= '{valid: ctl1_q.valid, neg: xneg};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= ax_d;
    end
  end

  assign ctl_o = ctl2_q;
  assign ax_o  = ax_q;
endmodule
`default_nettype wire

@@ hdl/stc_series.sv @@
// Term pipeline: one sine and one cosine term per stage, ratios one stage ahead.
// Depends on stc_pkg.
`default_nettype none
module stc_series import stc_pkg::*; #(
  parameter int unsigned SERIES_TERMS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire stc_ctl_t                ctl_i,
  input  wire logic [AX_W-1:0]         ax_i,
  input  wire logic [XSQ_W-1:0]        xsq_i,
  output stc_ctl_t                     ctl_o,
  output logic signed [SUM_W-1:0]      sine_sum_o,
  output logic signed [SUM_W-1:0]      cos_sum_o
);
  localparam int unsigned N = SERIES_TERMS;

  stc_ctl_t                ctl_q [N+1];
  logic [XSQ_W-1:0]        xsq_q [N-1];
  logic [TERM_W-1:0]       ts_q  [N];
  logic [TERM_W-1:0]       tc_q  [N];
  logic [XSQ_W-1:0]        rs_q  [N];
  logic [XSQ_W-1:0]        rc_q  [N];
  logic signed [SUM_W-1:0] ss_q  [N+1];
  logic signed [SUM_W-1:0] sc_q  [N+1];
  logic [XSQ_W-1:0]        rs_d  [N];
  logic [XSQ_W-1:0]        rc_d  [N];

  for (genvar j = 0; j < N; j++) begin : g_ratio
    localparam int unsigned DS = (2*j + 3) * (2*j + 2);
    localparam int unsigned DC = (2*j + 2) * (2*j + 1);
    localparam int unsigned LS = $clog2(DS);
    localparam int unsigned LC = $clog2(DC);
    localparam logic [63:0] MS = ((64'd1 << (XSQ_W + LS)) + 64'(DS) - 64'd1) / 64'(DS);
    localparam logic [63:0] MC = ((64'd1 << (XSQ_W + LC)) + 64'(DC) - 64'd1) / 64'(DC);
    logic [XSQ_W-1:0] src;
    logic [71:0]      ps;
    logic [71:0]      pc;
    if (j == 0) begin : g_first
      assign src = xsq_i;
    end else begin : g_next
      assign src = xsq_q[j-1];
    end
    assign ps      = 72'(src) * 72'(MS[35:0]);
    assign pc      = 72'(src) * 72'(MC[35:0]);
    assign rs_d[j] = XSQ_W'(ps >> (XSQ_W + LS));
    assign rc_d[j] = XSQ_W'(pc >> (XSQ_W + LC));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) ctl_q[i] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 0; i < N; i++) ctl_q[i+1] <= ctl_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xsq_q[0] <= xsq_i;
      ts_q[0]  <= TERM_W'(ax_i);
      tc_q[0]  <= ONE_TERM;
      ss_q[0]  <= SUM_W'(ax_i);
      sc_q[0]  <= SUM_W'(ONE_TERM);
      rs_q[0]  <= rs_d[0];
      rc_q[0]  <= rc_d[0];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_term
    logic [67:0]       pts, ptc;
    logic [TERM_W-1:0] tns, tnc;
    assign pts = 68'(ts_q[j]) * 68'(rs_q[j]);
    assign ptc = 68'(tc_q[j]) * 68'(rc_q[j]);
    assign tns = pts[FRAC +: TERM_W];
    assign tnc = ptc[FRAC +: TERM_W];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ((j % 2) == 0) begin
          ss_q[j+1] <= ss_q[j] - $signed(SUM_W'(tns));
          sc_q[j+1] <= sc_q[j] - $signed(SUM_W'(tnc));
        end else begin
          sc_q[j+1] <= sc_q[j] + $signed(SUM_W'(tnc));
          ss_q[j+1] <= ss_q[j] + $signed(SUM_W'(tns));
        end
      end
    end

    if (j + 1 < N) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ts_q[j+1] <= tns;
          tc_q[j+1] <= tnc;
          rs_q[j+1] <= rs_d[j+1];
          rc_q[j+1] <= rc_d[j+1];
        end
      end
    end
    if (j + 2 < N) begin : g_xsq
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          xsq_q[j+1] <= xsq_q[j];
        end
      end
    end
  end

  assign ctl_o      = ctl_q[N];
  assign sine_sum_o = ss_q[N];
  assign cos_sum_o  = sc_q[N];
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for sine_cosine_taylor: drives angles, predicts sine and cosine
// with a bit-exact fixed-point series model and checks every transaction.
// Depends on stc_pkg and the sine_cosine_taylor RTL.
`timescale 1ns / 1ps
module tb_top;
  import stc_pkg::*;

  localparam int unsigned N_TERMS   = 8;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LATENCY   = N_TERMS + 6;
  localparam int unsigned WD_LIMIT  = 5000;

  typedef struct packed {
    logic [31:0] sine;
    logic [31:0] cosine;
  } trig_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic signed [31:0] angle_i = '0;
  logic out_stall_i = 1'b1;
  logic in_stall_o, out_valid_o;
  logic signed [31:0] sine_o, cosine_o;

  trig_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit timed_out = 1'b0;
  bit gaps_on = 1'b1;
  bit hold_off = 1'b0;

  always #6 clk_i = ~clk_i;

  sine_cosine_taylor #(.SERIES_TERMS(N_TERMS), .TURN_FRACTION_BITS(FRAC_BITS)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .angle_i,
    .out_valid_o, .out_stall_i, .sine_o, .cosine_o
  );

  function automatic logic signed [63:0] series_sum(logic [63:0] first, int unsigned k0,
                                                    logic [63:0] xsq);
    logic signed [63:0] acc;
    logic [63:0] term, ratio;
    int unsigned k;
    acc = first;
    term = first;
    k = k0;
    for (int n = 0; n < N_TERMS; n++) begin
      k += 2;
      ratio = xsq / (64'(k) * 64'(k - 1));
      term = (term * ratio) >> 30;
      if (n & 1) acc += term;
      else acc -= term;
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] clamp_one(logic signed [63:0] v);
    if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
    if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
    return v;
  endfunction

  function automatic trig_t predict_trig(logic [31:0] raw);
    logic neg, xneg;
    logic [63:0] mag, ax, xsq, turns, fr, fmag;
    logic signed [63:0] s, c;
    trig_t r;
    neg = raw[31];
    mag = neg ? ((64'h1_0000_0000 - 64'(raw)) & 64'h1_FFFF_FFFF) : 64'(raw);
    if (mag > 64'(PI_Q24)) begin
      turns = (mag * 64'(INV_TWO_PI_Q32)) >> (56 - FRAC_BITS);
      if (neg) turns = 64'd0 - turns;
      fr = turns & ((64'd1 << FRAC_BITS) - 1);
      xneg = fr[FRAC_BITS-1];
      fmag = xneg ? ((64'd1 << FRAC_BITS) - fr) : fr;
      ax = (fmag * 64'(TWO_PI_Q29) + (64'd1 << (FRAC_BITS - 2))) >> (FRAC_BITS - 1);
    end else begin
      xneg = neg;
      ax = mag << 6;
    end
    xsq = (ax * ax) >> 30;
    s = series_sum(ax, 1, xsq);
    c = series_sum(64'd1 << 30, 0, xsq);
    if (xneg) s = -s;
    r.sine = 32'(clamp_one(s));
    r.cosine = 32'(clamp_one(c));
    return r;
  endfunction

  task automatic send_angle(logic [31:0] a);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_i <= a;
    expected_q.push_back(predict_trig(a));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic [31:0] pts[$];
    pts = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            PI_Q24, PI_Q24 + 1, -PI_Q24, -PI_Q24 - 1, 32'd26353589, -32'd26353589,
            32'd13176795, -32'd13176795, 32'd105414358, -32'd105414358, 32'h0100_0000,
            32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd158121537, 32'h0FFF_FFFF};
    foreach (pts[i]) send_angle(pts[i]);
    stop_sending();
  endtask

  task automatic test_random(int unsigned n);
    logic [31:0] a;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: a = $urandom;
        1: a = 32'($signed($urandom_range(0, 2 * PI_Q24)) - $signed(PI_Q24));
        2: a = $urandom_range(0, 32'hFF) ^ ($urandom_range(0, 1) ? PI_Q24 : -PI_Q24);
        default: a = 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      endcase
      send_angle(a);
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(60);
    join
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      stall_left = 0;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    trig_t exp_r;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h %h", sine_o, cosine_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.sine !== sine_o || exp_r.cosine !== cosine_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sin %h cos %h got sin %h cos %h",
                       exp_r.sine, exp_r.cosine, sine_o, cosine_o);
          end
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= WD_LIMIT);
    timed_out = 1'b1;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(800);
    test_backpressure();
    test_random(250);
    gaps_on = 1'b0;
    test_random(100);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/stc_pkg.sv
hdl/stc_reduce.sv
hdl/stc_series.sv
hdl/sine_cosine_taylor.sv
bench/tb_top.sv
